/* rtl/kmer_count_hash_table_defines.svh */
// Assertion macros used by the k-mer count table module.
`ifndef KMER_COUNT_HASH_TABLE_DEFINES_SVH
`define KMER_COUNT_HASH_TABLE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define KCHT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define KCHT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* rtl/kcht_pkg.sv */
// Package with types, constants and the key mixing function of the k-mer count table.
package kcht_pkg;
   localparam int unsigned SlotsDefault = 2048;
   localparam logic [11:0] ModulusReset = 12'd2039;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_SPARE  = 2'd3;

   localparam logic [1:0] ST_FOUND    = 2'd0;
   localparam logic [1:0] ST_INSERTED = 2'd1;
   localparam logic [1:0] ST_ABSENT   = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   // Index of the last of the seven key mixing steps.
   localparam logic [2:0] MixLastStep = 3'd6;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] kmer_key;
      logic [31:0] add_amount;
      logic [10:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] count_value;
      logic [63:0] key_value;
      logic [10:0] slot_number;
      logic [11:0] keys_held;
   } rsp_type;

   // Control from the sequencer to the modulo unit.
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [11:0] divisor;
   } mod_ctl_type;

   // One step of the shift-add-xor integer hash; the caller maps zero and one to two.
   function automatic logic [63:0] mix_step(input logic [63:0] h, input logic [2:0] step);
      logic [63:0] k;
      case (step)
         3'd0:    k = (~h) + (h << 21);
         3'd1:    k = h ^ (h >> 24);
         3'd2:    k = (h + (h << 3)) + (h << 8);
         3'd3:    k = h ^ (h >> 14);
         3'd4:    k = (h + (h << 2)) + (h << 4);
         3'd5:    k = h ^ (h >> 28);
         3'd6:    k = h + (h << 31);
         default: k = h;
      endcase
      return k;
   endfunction
endpackage

/* rtl/kcht_mod_unit.sv */
// Restoring bit-serial modulo unit: 64-bit dividend by 12-bit divisor, one bit per cycle.
module kcht_mod_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  kcht_pkg::mod_ctl_type ctl,
   output logic                 done,
   output logic [11:0]          remainder
);
   logic [63:0] dvd_ff, dvd_in;
   logic [12:0] rem_ff, rem_in;
   logic [11:0] div_ff, div_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [12:0] trial;

   // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[11:0], dvd_ff[63]};
      if (ctl.start) begin
         dvd_in  = ctl.dividend;
         rem_in  = 13'd0;
         div_in  = (ctl.divisor == 12'd0) ? 12'd1 : ctl.divisor;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[62:0], 1'b0};
         rem_in = (trial >= {1'b0, div_ff}) ? trial - {1'b0, div_ff} : trial;
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 7'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = busy_ff && (cnt_ff == 7'd63);
   assign remainder = rem_in[11:0];
endmodule

/* rtl/kmer_count_hash_table.sv */
// A request runs key mixing, then the modulo unit, then a slot read and a check per
// probe, a write for an add that writes, and the response; a slot read does one probe.
// One transaction is in flight at a time; the next waits until the response is taken.
// The bit-serial modulo unit and the single-port slot memory set the rate.
// After reset a clearing pass walks SLOTS valid entries, one per cycle,
// before the first request is accepted. Reset is synchronous, active high.
`include "kmer_count_hash_table_defines.svh"
module kmer_count_hash_table #(
   parameter int unsigned SLOTS = kcht_pkg::SlotsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  kcht_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output kcht_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [11:0]       csr_data
);
   localparam int unsigned AW = $clog2(SLOTS);
   localparam int unsigned CW = AW + 1;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_HASH, S_MOD, S_READ, S_CHECK, S_WRITE, S_RESP
   } state_type;

   state_type         state_ff;
   logic [11:0]       modulus_ff;
   kcht_pkg::req_type req_ff;
   kcht_pkg::rsp_type rsp_ff;
   logic [AW-1:0]     idx_ff;
   logic [CW-1:0]     probe_ff;
   logic [CW-1:0]     keys_ff;
   logic              rsp_valid_ff;
   logic [63:0]       hash_ff;
   logic [2:0]        hstep_ff;

   // Slot memory: valid bits, keys and counts, read data registered.
   logic              vmem [SLOTS];
   logic [63:0]       kmem [SLOTS];
   logic [31:0]       cmem [SLOTS];
   logic              rd_v_ff;
   logic [63:0]       rd_k_ff;
   logic [31:0]       rd_c_ff;
   logic              we;
   logic [AW-1:0]     waddr;
   logic              wv;
   logic [63:0]       wk;
   logic [31:0]       wc;

   kcht_pkg::mod_ctl_type mod_ctl;
   logic                  mod_done;
   logic [11:0]           mod_rem;
   logic [32:0]           sum;
   logic [31:0]           sat;
   logic [11:0]           home;
   logic [63:0]           mix_next;

   kcht_mod_unit u_mod (
      .clock(clock), .reset(reset), .ctl(mod_ctl),
      .done(mod_done), .remainder(mod_rem)
   );

   assign sum  = {1'b0, rd_c_ff} + {1'b0, req_ff.add_amount};
   assign sat  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   assign home = mod_rem & 12'(SLOTS - 1);

   // Key mixing, one step per cycle; the last step starts the modulo unit.
   always_comb begin
      mix_next         = kcht_pkg::mix_step(hash_ff, hstep_ff);
      mod_ctl.start    = (state_ff == S_HASH) && (hstep_ff == kcht_pkg::MixLastStep);
      mod_ctl.dividend = (mix_next <= 64'd1) ? 64'd2 : mix_next;
      mod_ctl.divisor  = modulus_ff;
   end

   // Memory write port.
   always_comb begin
      we    = 1'b0;
      waddr = idx_ff;
      wv    = 1'b1;
      wk    = req_ff.kmer_key;
      wc    = req_ff.add_amount;
      if (state_ff == S_CLEAR) begin
         we = 1'b1;
         wv = 1'b0;
      end else if (state_ff == S_WRITE) begin
         we = 1'b1;
         if (rd_v_ff) begin
            wc = sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         vmem[waddr] <= wv;
         kmem[waddr] <= wk;
         cmem[waddr] <= wc;
      end
      rd_v_ff <= vmem[idx_ff];
      rd_k_ff <= kmem[idx_ff];
      rd_c_ff <= cmem[idx_ff];
   end

   // Sequencer: clear pass, hash and modulo, probe walk, response.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         keys_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= kcht_pkg::ModulusReset;
      end else begin
         if (csr_write) begin
            modulus_ff <= csr_data;
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               idx_ff <= idx_ff + AW'(1);
               if (idx_ff == AW'(SLOTS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  req_ff   <= req_data;
                  probe_ff <= '0;
                  if (req_data.opcode inside {kcht_pkg::OP_ADD, kcht_pkg::OP_LOOKUP}) begin
                     hash_ff  <= req_data.kmer_key;
                     hstep_ff <= '0;
                     state_ff <= S_HASH;
                  end else if (req_data.opcode == kcht_pkg::OP_READ &&
                               32'(req_data.slot_index) < SLOTS) begin
                     idx_ff   <= AW'(req_data.slot_index);
                     state_ff <= S_READ;
                  end else begin
                     rsp_ff.status      <= kcht_pkg::ST_ABSENT;
                     rsp_ff.count_value <= '0;
                     rsp_ff.key_value   <= '0;
                     rsp_ff.slot_number <= (req_data.opcode == kcht_pkg::OP_READ) ?
                                           req_data.slot_index : 11'd0;
                     state_ff <= S_RESP;
                  end
               end
            end
            S_HASH: begin
               hash_ff  <= mix_next;
               hstep_ff <= hstep_ff + 3'd1;
               if (hstep_ff == kcht_pkg::MixLastStep) begin
                  state_ff <= S_MOD;
               end
            end
            S_MOD: begin
               if (mod_done) begin
                  idx_ff   <= AW'(home);
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_CHECK;
            S_CHECK: begin
               rsp_ff.slot_number <= 11'(idx_ff);
               if (req_ff.opcode == kcht_pkg::OP_READ) begin
                  rsp_ff.status      <= rd_v_ff ? kcht_pkg::ST_FOUND : kcht_pkg::ST_ABSENT;
                  rsp_ff.count_value <= rd_v_ff ? rd_c_ff : 32'd0;
                  rsp_ff.key_value   <= rd_v_ff ? rd_k_ff : 64'd0;
                  state_ff           <= S_RESP;
               end else if (!rd_v_ff || rd_k_ff == req_ff.kmer_key) begin
                  if (req_ff.opcode == kcht_pkg::OP_ADD) begin
                     rsp_ff.status      <= rd_v_ff ? kcht_pkg::ST_FOUND
                                                   : kcht_pkg::ST_INSERTED;
                     rsp_ff.count_value <= rd_v_ff ? sat : req_ff.add_amount;
                     rsp_ff.key_value   <= req_ff.kmer_key;
                     state_ff           <= S_WRITE;
                  end else begin
                     rsp_ff.status      <= rd_v_ff ? kcht_pkg::ST_FOUND : kcht_pkg::ST_ABSENT;
                     rsp_ff.count_value <= rd_v_ff ? rd_c_ff : 32'd0;
                     rsp_ff.key_value   <= rd_v_ff ? req_ff.kmer_key : 64'd0;
                     if (!rd_v_ff) begin
                        rsp_ff.slot_number <= 11'd0;
                     end
                     state_ff <= S_RESP;
                  end
               end else if (probe_ff == CW'(SLOTS - 1)) begin
                  rsp_ff.status      <= (req_ff.opcode == kcht_pkg::OP_ADD) ?
                                        kcht_pkg::ST_FULL : kcht_pkg::ST_ABSENT;
                  rsp_ff.count_value <= '0;
                  rsp_ff.key_value   <= '0;
                  rsp_ff.slot_number <= '0;
                  state_ff           <= S_RESP;
               end else begin
                  idx_ff   <= idx_ff + probe_ff[AW-1:0] + AW'(1);
                  probe_ff <= probe_ff + CW'(1);
                  state_ff <= S_READ;
               end
            end
            S_WRITE: begin
               if (!rd_v_ff) begin
                  keys_ff <= keys_ff + CW'(1);
               end
               state_ff <= S_RESP;
            end
            S_RESP: begin
               rsp_ff.keys_held <= 12'(keys_ff);
               rsp_valid_ff     <= 1'b1;
               state_ff         <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `KCHT_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == S_IDLE)
   `KCHT_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready)
   `KCHT_ASSERT_IMP(a_keys_bound, clock, reset, 1'b1, 32'(keys_ff) <= SLOTS)
endmodule
